// ===== rtl/mtra_pkg.sv =====
// ----------------------------------------------------------------------------
// mtra_pkg
// Shared types, constants and helpers for the machine timer register access
// core.
// ----------------------------------------------------------------------------
package mtra_pkg;

    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [2:0] LANE_MASK = 3'h7;

    localparam logic [ADDR_W-1:0] TIME_ADDR_RESET    = 64'h0000_0000_0200_BFF8;
    localparam logic [ADDR_W-1:0] COMPARE_ADDR_RESET = 64'h0000_0000_0200_4000;

    localparam logic [1:0] PRIV_MACHINE = 2'd3;
    localparam logic       MODE_WRITE   = 1'b1;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_ADDR    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_ADDR = 1'b1;

    localparam int unsigned IN_TDATA_W  = 136;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [1:0]        access_width;
        logic [DATA_W-1:0] write_data;
        logic [1:0]        priv_level;
        logic              mprv;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic              timer_pending;
    } res_t;

    typedef struct packed {
        logic              commit;
        logic [DATA_W-1:0] time_value;
        logic [DATA_W-1:0] compare_value;
        logic              pending;
    } upd_t;

    function automatic logic [DATA_W-1:0] field_mask(input logic [1:0] code);
        logic [DATA_W-1:0] m;
        case (code)
            SIZE_BYTE: m = 64'h0000_0000_0000_00FF;
            SIZE_HALF: m = 64'h0000_0000_0000_FFFF;
            SIZE_WORD: m = 64'h0000_0000_FFFF_FFFF;
            default:   m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] align_mask(input logic [1:0] code);
        logic [2:0] m;
        case (code)
            SIZE_BYTE: m = 3'b000;
            SIZE_HALF: m = 3'b001;
            SIZE_WORD: m = 3'b011;
            default:   m = LANE_MASK;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/mtra_access.sv =====
// ----------------------------------------------------------------------------
// mtra_access
// Address decode, lane extract/merge and pending compare for one access.
// ----------------------------------------------------------------------------
module mtra_access
    import mtra_pkg::*;
(
    input  req_t              req,
    input  logic [ADDR_W-1:0] time_address,
    input  logic [ADDR_W-1:0] compare_address,
    input  logic [DATA_W-1:0] time_value,
    input  logic [DATA_W-1:0] compare_value,
    input  logic              pending,
    output res_t              res,
    output upd_t              upd
);

    logic [ADDR_W-1:0] word_addr;
    logic              aligned;
    logic              allowed;
    logic              sel_time;
    logic              sel_compare;
    logic              is_write;
    logic [5:0]        shift;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] lanes;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] merged;
    logic [DATA_W-1:0] time_new;
    logic [DATA_W-1:0] compare_new;
    logic              pending_new;

    always_comb
    begin
        word_addr   = {req.address[ADDR_W-1:3], 3'b000};
        aligned     = (req.address[2:0] & align_mask(req.access_width)) == 3'b000;
        allowed     = (req.priv_level == PRIV_MACHINE) && !req.mprv;
        sel_time    = aligned && allowed && (word_addr == time_address);
        sel_compare = aligned && allowed && !sel_time && (word_addr == compare_address);
        is_write    = req.mode == MODE_WRITE;

        shift  = {req.address[2:0], 3'b000};
        mask   = field_mask(req.access_width);
        lanes  = mask << shift;
        target = sel_time ? time_value : compare_value;
        merged = (target & ~lanes) | ((req.write_data & mask) << shift);

        time_new    = (sel_time && is_write) ? merged : time_value;
        compare_new = (sel_compare && is_write) ? merged : compare_value;
        pending_new = time_new >= compare_new;

        res.hit           = sel_time || sel_compare;
        res.read_data     = (res.hit && !is_write) ? ((target >> shift) & mask) : '0;
        res.timer_pending = (res.hit && is_write) ? pending_new : pending;

        upd.commit        = res.hit && is_write;
        upd.time_value    = time_new;
        upd.compare_value = compare_new;
        upd.pending       = pending_new;
    end

endmodule

// ===== rtl/machine_timer_register_access_core.sv =====
// ----------------------------------------------------------------------------
// machine_timer_register_access_core
// mtime / mtimecmp register access with timer pending flag.
// ----------------------------------------------------------------------------
//  channel   | signals                               | payload
//  ----------+---------------------------------------+------------------------
//  s_axis    | s_axis_tvalid/tready/tdata/tuser      | one access word
//  m_axis    | m_axis_tvalid/tready/tdata            | one result word
//  cfg       | cfg_we/cfg_index/cfg_data             | register address writes
//
//  One word per cycle while m_axis_tready allows; an access passes the input
//  register, then decode/merge/compare into the result register.
//  Timer state commits as a word moves into the result register, so the next
//  word sees it at once.
//  m_axis_tready low holds the result; the input stage keeps one word queued.
//  Reset clears valids, timer state and loads the default register addresses.
// ----------------------------------------------------------------------------
module machine_timer_register_access_core
    import mtra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] address, [65:64] access_width, [129:66] write_data,
    // [131:130] priv_level, [132] mprv, [135:133] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] hit, [64:1] read_data, [65] timer_pending, [71:66] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    req_t              in_req_reg;
    req_t              in_req_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              out_res_reg;
    res_t              out_res_next;
    logic [ADDR_W-1:0] time_address_reg;
    logic [ADDR_W-1:0] compare_address_reg;
    logic [DATA_W-1:0] time_value_reg;
    logic [DATA_W-1:0] compare_value_reg;
    logic              pending_reg;
    logic              advance;
    req_t              s_req;
    res_t              res;
    upd_t              upd;

    assign s_req.mode         = s_axis_tuser;
    assign s_req.address      = s_axis_tdata[63:0];
    assign s_req.access_width = s_axis_tdata[65:64];
    assign s_req.write_data   = s_axis_tdata[129:66];
    assign s_req.priv_level   = s_axis_tdata[131:130];
    assign s_req.mprv         = s_axis_tdata[132];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mtra_access u_access (
        .req             (in_req_reg),
        .time_address    (time_address_reg),
        .compare_address (compare_address_reg),
        .time_value      (time_value_reg),
        .compare_value   (compare_value_reg),
        .pending         (pending_reg),
        .res             (res),
        .upd             (upd)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_req_next    = in_req_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            in_req_next   = s_req;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg  <= in_req_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_value_reg    <= '0;
            compare_value_reg <= '0;
            pending_reg       <= 1'b0;
        end
        else if (advance && upd.commit)
        begin
            time_value_reg    <= upd.time_value;
            compare_value_reg <= upd.compare_value;
            pending_reg       <= upd.pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_address_reg    <= TIME_ADDR_RESET;
            compare_address_reg <= COMPARE_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_ADDR:    time_address_reg    <= cfg_data;
                CFG_COMPARE_ADDR: compare_address_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_res_reg.timer_pending,
                            out_res_reg.read_data, out_res_reg.hit};

    // a missed access never touches timer state
    a_miss_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !res.hit |=> $stable(time_value_reg) && $stable(compare_value_reg)
            && $stable(pending_reg))
        else $error("timer state changed on a missed access");

    // pending tracks the compare after every committed write
    a_pending_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd.commit |=> pending_reg == (time_value_reg >= compare_value_reg))
        else $error("pending flag out of step with compare");

    // only machine mode with mprv clear is claimed
    a_hit_privileged: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.hit |-> in_req_reg.priv_level == PRIV_MACHINE && !in_req_reg.mprv)
        else $error("unprivileged access claimed");

    // a word leaving the input stage always lands in the result register
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost on advance");

endmodule

// ===== bench/tb_machine_timer_register_access_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_machine_timer_register_access_core
// Self-checking bench for the mtime / mtimecmp access core: a directed table
// of accesses followed by random traffic over several register address
// settings and idle/stall mixes, every result word checked against a
// cycle-free timer register model or a directed row's expected result.
// ----------------------------------------------------------------------------
module tb_machine_timer_register_access_core;
    import mtra_pkg::*;

    localparam logic       MODE_READ       = 1'b0;
    localparam logic [1:0] PRIV_USER       = 2'd0;
    localparam logic [1:0] PRIV_SUPER      = 2'd1;
    localparam logic [1:0] PRIV_HYPER      = 2'd2;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         WORDS_PER_MIX   = 60;
    localparam int         NUM_SETTINGS    = 6;
    localparam int         PRINT_LIMIT     = 100;

    typedef struct {
        req_t acc;
        bit   typed;
        res_t want;
    } access_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;

    // timer model
    logic [63:0] time_addr_cfg = TIME_ADDR_RESET;
    logic [63:0] cmp_addr_cfg = COMPARE_ADDR_RESET;
    logic [63:0] mtime_model = '0;
    logic [63:0] mtimecmp_model = '0;
    logic        pending_model = 1'b0;

    res_t        timer_results_q[$];
    int          mismatch_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;

    machine_timer_register_access_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic res_t timer_access(input req_t acc);
        logic [63:0] size_mask;
        logic [63:0] lane_mask;
        logic [63:0] word;
        int unsigned shift;
        logic        aligned;
        logic        allowed;
        logic        to_time;
        logic        to_cmp;
        res_t        r;
        size_mask = (acc.access_width == SIZE_DWORD) ? {64{1'b1}}
                  : (64'd1 << (8 << acc.access_width)) - 64'd1;
        shift     = acc.address[2:0] * 8;
        lane_mask = size_mask << shift;
        word      = {acc.address[63:3], 3'b000};
        aligned   = (acc.address & ((64'd1 << acc.access_width) - 64'd1)) == 64'd0;
        allowed   = (acc.priv_level == PRIV_MACHINE) && !acc.mprv;
        to_time   = aligned && allowed && (word == time_addr_cfg);
        to_cmp    = aligned && allowed && !to_time && (word == cmp_addr_cfg);
        r.hit       = to_time || to_cmp;
        r.read_data = '0;
        if (acc.mode == MODE_WRITE)
        begin
            if (to_time)
                mtime_model = (mtime_model & ~lane_mask)
                            | ((acc.write_data & size_mask) << shift);
            if (to_cmp)
                mtimecmp_model = (mtimecmp_model & ~lane_mask)
                               | ((acc.write_data & size_mask) << shift);
            if (r.hit)
                pending_model = mtime_model >= mtimecmp_model;
        end
        else if (to_time)
            r.read_data = (mtime_model >> shift) & size_mask;
        else if (to_cmp)
            r.read_data = (mtimecmp_model >> shift) & size_mask;
        r.timer_pending = pending_model;
        return r;
    endfunction

    function automatic access_row_t make_row(input logic mode, input logic [63:0] addr,
                                             input logic [1:0] code, input logic [63:0] wdata,
                                             input logic [1:0] priv, input logic mprv,
                                             input bit typed = 1'b0, input logic hit = 1'b0,
                                             input logic [63:0] rdata = '0,
                                             input logic pend = 1'b0);
        access_row_t row;
        row.acc.mode            = mode;
        row.acc.address         = addr;
        row.acc.access_width    = code;
        row.acc.write_data      = wdata;
        row.acc.priv_level      = priv;
        row.acc.mprv            = mprv;
        row.typed               = typed;
        row.want.hit            = hit;
        row.want.read_data      = rdata;
        row.want.timer_pending  = pend;
        return row;
    endfunction

    function automatic req_t random_access();
        req_t        a;
        int unsigned pick;
        pick   = $urandom_range(99);
        a.mode = 1'($urandom_range(1));
        if (pick < 40)
            a.address = {time_addr_cfg[63:3], 3'($urandom_range(7))};
        else if (pick < 70)
            a.address = {cmp_addr_cfg[63:3], 3'($urandom_range(7))};
        else if (pick < 80)
            a.address = ($urandom_range(1) != 0) ? time_addr_cfg : cmp_addr_cfg;
        else
            a.address = {$urandom, $urandom};
        a.access_width = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 15)
            a.write_data = '0;
        else if (pick < 30)
            a.write_data = '1;
        else
            a.write_data = {$urandom, $urandom};
        a.priv_level = ($urandom_range(99) < 80) ? PRIV_MACHINE : 2'($urandom_range(3));
        a.mprv       = $urandom_range(99) < 10;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task automatic send_access(input req_t acc, input bit typed, input res_t want);
        res_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, acc.mprv, acc.priv_level, acc.write_data,
                          acc.access_width, acc.address};
        s_axis_tuser  <= acc.mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = timer_access(acc);
        timer_results_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (timer_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_addresses(input logic [63:0] t_addr, input logic [63:0] c_addr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_ADDR;
        cfg_data  <= t_addr;
        @(posedge clk);
        cfg_index <= CFG_COMPARE_ADDR;
        cfg_data  <= c_addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        time_addr_cfg = t_addr;
        cmp_addr_cfg  = c_addr;
    endtask

    // receiver: long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (timer_results_q.size() == 0)
                report_mismatch("word with nothing expected", m_axis_tdata[63:0], '0);
            else
            begin
                want = timer_results_q.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                    report_mismatch("hit", 64'(m_axis_tdata[0]), 64'(want.hit));
                if (m_axis_tdata[64:1] !== want.read_data)
                    report_mismatch("read_data", m_axis_tdata[64:1], want.read_data);
                if (m_axis_tdata[65] !== want.timer_pending)
                    report_mismatch("timer_pending", 64'(m_axis_tdata[65]),
                                    64'(want.timer_pending));
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        access_row_t directed_q[$];
        logic [63:0] time_sets[NUM_SETTINGS];
        logic [63:0] cmp_sets[NUM_SETTINGS];
        int          mix_idle[4];
        int          mix_stall[4];
        res_t        no_want;
        logic [63:0] ta;
        logic [63:0] ca;
        ta       = TIME_ADDR_RESET;
        ca       = COMPARE_ADDR_RESET;
        no_want  = '0;
        mix_idle  = '{0, 61, 0, 31};
        mix_stall = '{0, 0, 61, 31};
        time_sets = '{64'h0, 64'hFFFF_FFFF_FFFF_FFF8, 64'h1000, 64'h2003,
                      {$urandom, $urandom} & ~64'h7, TIME_ADDR_RESET};
        cmp_sets  = '{64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 64'h1000, 64'h3000,
                      {$urandom, $urandom} & ~64'h7, COMPARE_ADDR_RESET};

        directed_q.push_back(make_row(MODE_READ,  ta, SIZE_DWORD, '1, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ca, SIZE_DWORD, '1, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ta, SIZE_DWORD, '1, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b1));
        directed_q.push_back(make_row(MODE_READ,  ta, SIZE_DWORD, '0, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '1, 1'b1));
        // equal values still count as pending
        directed_q.push_back(make_row(MODE_WRITE, ca, SIZE_DWORD, '1, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b1));
        directed_q.push_back(make_row(MODE_WRITE, ta, SIZE_BYTE, '0, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ta + 1, SIZE_BYTE, '0, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, 64'hFF, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ta + 2, SIZE_HALF, '0, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ca + 4, SIZE_WORD, 64'hDEAD_BEEF_1234_5678,
                                      PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ca + 4, SIZE_WORD, '1, PRIV_MACHINE, 1'b0));
        // misaligned
        directed_q.push_back(make_row(MODE_READ,  ta + 1, SIZE_HALF, '1, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ta + 2, SIZE_WORD, '0, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ca + 4, SIZE_DWORD, '0, PRIV_MACHINE, 1'b0));
        // privilege and mprv blocking
        directed_q.push_back(make_row(MODE_WRITE, ta, SIZE_DWORD, '0, PRIV_USER, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ta, SIZE_DWORD, '0, PRIV_SUPER, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  ca, SIZE_DWORD, '0, PRIV_HYPER, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ta, SIZE_DWORD, '0, PRIV_MACHINE, 1'b1));
        // address extremes, no register there
        directed_q.push_back(make_row(MODE_READ,  64'h0, SIZE_DWORD, '0, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_READ,  '1, SIZE_BYTE, '1, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, SIZE_DWORD, '1,
                                      PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ta + 7, SIZE_BYTE, 64'hAB, PRIV_MACHINE,
                                      1'b0));
        directed_q.push_back(make_row(MODE_READ,  ta, SIZE_DWORD, '0, PRIV_MACHINE, 1'b0));
        directed_q.push_back(make_row(MODE_WRITE, ca, SIZE_DWORD, '0, PRIV_MACHINE, 1'b0,
                                      1'b1, 1'b1, '0, 1'b1));
        directed_q.push_back(make_row(MODE_WRITE, ta + 6, SIZE_HALF, 64'h5A5A_0000,
                                      PRIV_MACHINE, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
            send_access(directed_q[i].acc, directed_q[i].typed, directed_q[i].want);
        drain_results();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            load_addresses(time_sets[s], cmp_sets[s]);
            for (int m = 0; m < 4; m++)
            begin
                idle_pct  = mix_idle[m];
                stall_pct = mix_stall[m];
                // back up the output so the input stage fills and stalls
                if (s == 0 && m == 0)
                    hold_req = 300;
                repeat (WORDS_PER_MIX) send_access(random_access(), 1'b0, no_want);
                drain_results();
            end
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mtra_pkg.sv
rtl/mtra_access.sv
rtl/machine_timer_register_access_core.sv
bench/tb_machine_timer_register_access_core.sv
